/* hdl/button_multiclick_classifier_core_macros.svh */
// assertion macros shared by the rtl
`ifndef BUTTON_MULTICLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_MULTICLICK_CLASSIFIER_CORE_MACROS_SVH

// condition must hold at every edge outside reset
`define BMC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// same-cycle implication outside reset
`define BMC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication outside reset
`define BMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bmc_pkg.sv */
package bmc_pkg;

    localparam int NUM_BUTTONS_DEF = 4;

    localparam int BUTTON_W   = 2;
    localparam int TIME_W     = 32;
    localparam int INTEG_W    = 8;
    localparam int CLICK_W    = 4;
    localparam int HOLD_W     = 2;
    localparam int GEST_W     = 3;
    localparam int BIU_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [CLICK_W-1:0] FR_CLICKS      = 4'd5;
    localparam logic [CLICK_W-1:0] BATTERY_CLICKS = 4'd4;
    localparam logic [CLICK_W-1:0] CLICK_MAX      = 4'd15;

    // per-button hold phase
    localparam logic [1:0] HP_NONE    = 2'd0;
    localparam logic [1:0] HP_PRESENT = 2'd1;
    localparam logic [1:0] HP_FIXED   = 2'd2;

    // hold_event codes
    localparam logic [HOLD_W-1:0] HOLD_NONE     = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_START    = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_FR_START = 2'd2;

    // gesture codes
    localparam logic [GEST_W-1:0] GEST_NONE         = 3'd0;
    localparam logic [GEST_W-1:0] GEST_SINGLE       = 3'd1;
    localparam logic [GEST_W-1:0] GEST_DOUBLE       = 3'd2;
    localparam logic [GEST_W-1:0] GEST_TRIPLE       = 3'd3;
    localparam logic [GEST_W-1:0] GEST_BATTERY      = 3'd4;
    localparam logic [GEST_W-1:0] GEST_HOLD_RELEASE = 3'd5;
    localparam logic [GEST_W-1:0] GEST_RESET_ARMED  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_WINDOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS_USED = 2'd3;

    localparam logic [INTEG_W-1:0] INTEG_REST = 8'd1;

    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] t,
                                     input logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] diff;
        diff = now - t;
        return diff > span;
    endfunction

endpackage

/* hdl/button_multiclick_classifier_core.sv */
// Multi-click / long-press classifier for polled buttons.
// Input stream s_*: one transaction per poll carrying the button index, its
// pin level (1 = pressed) and a free-running 32-bit tick count. Output stream
// m_*: exactly one result transaction per poll with hold event, gesture,
// debounced press/release edges and the busy flag.
// Configuration: cfg_we writes register cfg_index (0 debounce top, 1 click
// gap, 2 arm window, 3 buttons in use) with cfg_wdata; write only while idle.
// A poll is registered on acceptance and evaluated once the result register
// can advance; the button's state is then read, updated and written back
// together with the result register, whose valid flag drives m_tvalid.
// One poll per clock is sustained while m_tready stays high, as each button's
// state update is computed combinationally from the input register.
// Reset (aresetn low, synchronous) empties both registers, clears all button
// state, the factory-reset arm and restores the configuration defaults.
// When m_tready is low the result is held; one more poll is still taken into
// the input register, after which s_tready drops until the result is taken.
`include "button_multiclick_classifier_core_macros.svh"

module button_multiclick_classifier_core
    import bmc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] button, [2] pin_active, [34:3] now, [39:35] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] hold_event, [4:2] gesture, [5] press_edge, [6] release_edge,
    // [7] busy_res
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int BX_W  = (IDX_W > BUTTON_W) ? IDX_W : BUTTON_W;

    // configuration
    logic [INTEG_W-1:0] debounce_top_reg;
    logic [TIME_W-1:0]  click_gap_reg;
    logic [TIME_W-1:0]  arm_window_reg;
    logic [BIU_W-1:0]   buttons_in_use_reg;

    // per-button state
    logic [INTEG_W-1:0] integ_reg    [NUM_BUTTONS];
    logic               pressed_reg  [NUM_BUTTONS];
    logic               released_reg [NUM_BUTTONS];
    logic [1:0]         hold_reg     [NUM_BUTTONS];
    logic [CLICK_W-1:0] click_reg    [NUM_BUTTONS];
    logic [TIME_W-1:0]  lpt_reg      [NUM_BUTTONS];
    logic               armed_reg;
    logic [TIME_W-1:0]  armed_time_reg;

    // input register
    logic                in_valid_reg;
    logic [BUTTON_W-1:0] in_button_reg;
    logic                in_active_reg;
    logic [TIME_W-1:0]   in_now_reg;

    // result register
    logic                out_valid_reg;
    logic [HOLD_W-1:0]   out_hold_reg;
    logic [GEST_W-1:0]   out_gest_reg;
    logic                out_pe_reg;
    logic                out_re_reg;
    logic                out_busy_reg;

    logic advance;
    logic eval;

    // next values of the polled button and globals
    logic [INTEG_W-1:0] integ_next;
    logic               pressed_next;
    logic               released_next;
    logic [1:0]         hold_next;
    logic [CLICK_W-1:0] click_next;
    logic [TIME_W-1:0]  lpt_next;
    logic               armed_next;
    logic [TIME_W-1:0]  armed_time_next;
    logic [HOLD_W-1:0]  hold_ev_next;
    logic [GEST_W-1:0]  gest_next;
    logic               pe_next;
    logic               re_next;
    logic               busy_next;
    logic               in_range;
    logic [IDX_W-1:0]   idx;

    assign advance  = !out_valid_reg || m_tready;
    assign eval     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        logic [BX_W-1:0] bx;
        logic            el;
        bx       = BX_W'(in_button_reg);
        idx      = bx[IDX_W-1:0];
        in_range = 32'(in_button_reg) < NUM_BUTTONS;

        integ_next      = integ_reg[idx];
        pressed_next    = pressed_reg[idx];
        released_next   = released_reg[idx];
        hold_next       = hold_reg[idx];
        click_next      = click_reg[idx];
        lpt_next        = lpt_reg[idx];
        armed_time_next = armed_time_reg;
        hold_ev_next    = HOLD_NONE;
        gest_next       = GEST_NONE;
        pe_next         = 1'b0;
        re_next         = 1'b0;

        armed_next = armed_reg && !elapsed(in_now_reg, armed_time_reg, arm_window_reg);
        el         = elapsed(in_now_reg, lpt_reg[idx], click_gap_reg);

        if (in_range) begin
            if (in_active_reg) begin
                if (pressed_next && el && hold_next == HP_NONE) begin
                    hold_next = HP_PRESENT;
                    if (!armed_next) begin
                        hold_ev_next = HOLD_START;
                    end else begin
                        hold_ev_next = HOLD_FR_START;
                        armed_next   = 1'b0;
                    end
                end
                if (integ_next != debounce_top_reg) begin
                    integ_next = integ_next + INTEG_W'(1);
                    if (integ_next == debounce_top_reg) begin
                        pressed_next = 1'b1;
                        pe_next      = 1'b1;
                        if (!el) begin
                            if (click_next < CLICK_MAX) begin
                                click_next = click_next + CLICK_W'(1);
                            end
                        end else begin
                            click_next = CLICK_W'(1);
                        end
                        lpt_next = in_now_reg;
                        // gap restarts at this press
                        el = 1'b0;
                    end
                end
            end else begin
                if (integ_next != INTEG_REST) begin
                    integ_next = integ_next - INTEG_W'(1);
                    if (integ_next == INTEG_REST && (pressed_next || hold_next == HP_FIXED)) begin
                        released_next = 1'b1;
                        re_next       = 1'b1;
                    end
                end
            end

            if (released_next && el) begin
                if (click_next >= FR_CLICKS) begin
                    armed_next      = 1'b1;
                    armed_time_next = in_now_reg;
                    gest_next       = GEST_RESET_ARMED;
                end else if (hold_next != HP_NONE) begin
                    gest_next = GEST_HOLD_RELEASE;
                end else if (click_next >= CLICK_W'(1) && click_next <= CLICK_W'(3)) begin
                    gest_next = GEST_W'(click_next);
                end else if (click_next == BATTERY_CLICKS) begin
                    gest_next = GEST_BATTERY;
                end
                click_next    = '0;
                pressed_next  = 1'b0;
                released_next = 1'b0;
                hold_next     = HP_NONE;
            end else if (pressed_next && click_next == CLICK_W'(1) && hold_next == HP_PRESENT) begin
                // long hold on a single press: fixed hold, count dropped
                hold_next    = HP_FIXED;
                click_next   = '0;
                pressed_next = 1'b0;
            end
        end
    end

    // busy over the buttons in use, polled button taken after its update
    always_comb begin
        logic               self;
        logic [INTEG_W-1:0] iv;
        logic               pv;
        logic [CLICK_W-1:0] cv;
        busy_next = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            self = in_range && idx == IDX_W'(i);
            iv   = self ? integ_next   : integ_reg[i];
            pv   = self ? pressed_next : pressed_reg[i];
            cv   = self ? click_next   : click_reg[i];
            if (i < 32'(buttons_in_use_reg) &&
                ((iv != INTEG_REST && iv != debounce_top_reg) || pv || cv != '0)) begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_top_reg   <= 8'd5;
            click_gap_reg      <= 32'd750;
            arm_window_reg     <= 32'd3000;
            buttons_in_use_reg <= 3'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE_TOP: debounce_top_reg   <= cfg_wdata[INTEG_W-1:0];
                CFG_CLICK_GAP:    click_gap_reg      <= cfg_wdata[TIME_W-1:0];
                CFG_ARM_WINDOW:   arm_window_reg     <= cfg_wdata[TIME_W-1:0];
                CFG_BUTTONS_USED: buttons_in_use_reg <= cfg_wdata[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                integ_reg[i]    <= INTEG_REST;
                pressed_reg[i]  <= 1'b0;
                released_reg[i] <= 1'b0;
                hold_reg[i]     <= HP_NONE;
                click_reg[i]    <= '0;
                lpt_reg[i]      <= '0;
            end
            armed_reg      <= 1'b0;
            armed_time_reg <= '0;
        end else if (eval) begin
            if (in_range) begin
                integ_reg[idx]    <= integ_next;
                pressed_reg[idx]  <= pressed_next;
                released_reg[idx] <= released_next;
                hold_reg[idx]     <= hold_next;
                click_reg[idx]    <= click_next;
                lpt_reg[idx]      <= lpt_next;
            end
            armed_reg      <= armed_next;
            armed_time_reg <= armed_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_button_reg <= s_tdata[1:0];
            in_active_reg <= s_tdata[2];
            in_now_reg    <= s_tdata[34:3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval) begin
            out_hold_reg <= hold_ev_next;
            out_gest_reg <= gest_next;
            out_pe_reg   <= pe_next;
            out_re_reg   <= re_next;
            out_busy_reg <= busy_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_busy_reg, out_re_reg, out_pe_reg, out_gest_reg, out_hold_reg};

    `BMC_ASSERT_ALWAYS(a_edges_exclusive,
        !(out_valid_reg && out_pe_reg && out_re_reg),
        "press and release edge in one result")
    `BMC_ASSERT_IMPLIES(a_out_from_input,
        $rose(out_valid_reg), $past(in_valid_reg),
        "result without a held poll")
    `BMC_ASSERT_IMPLIES(a_arm_reported,
        $rose(armed_reg), out_gest_reg == GEST_RESET_ARMED,
        "reset arm set without its gesture")
    `BMC_ASSERT_NEXT(a_held_poll_kept,
        in_valid_reg && !advance, in_valid_reg && $stable(in_now_reg),
        "held poll lost while stalled")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bmc_pkg::*;

    typedef struct packed {
        logic              busy;
        logic              release_edge;
        logic              press_edge;
        logic [GEST_W-1:0] gesture;
        logic [HOLD_W-1:0] hold_event;
    } poll_report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [1:0] button, [2] pin_active, [34:3] now, [39:35] zero
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [1:0] hold_event, [4:2] gesture, [5] press_edge, [6] release_edge, [7] busy_res
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    button_multiclick_classifier_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of the configuration
    logic [INTEG_W-1:0] cfg_top = 8'd5;
    logic [TIME_W-1:0]  cfg_gap = 32'd750;
    logic [TIME_W-1:0]  cfg_window = 32'd3000;
    logic [BIU_W-1:0]   cfg_used = 3'd1;

    // predictor copy of the button state
    logic [INTEG_W-1:0] integ_q      [NUM_BUTTONS_DEF];
    logic               pressed_q    [NUM_BUTTONS_DEF];
    logic               released_q   [NUM_BUTTONS_DEF];
    logic [HOLD_W-1:0]  phase_q      [NUM_BUTTONS_DEF];
    logic [CLICK_W-1:0] clicks_q     [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0]  press_time_q [NUM_BUTTONS_DEF];
    logic               armed_q = 1'b0;
    logic [TIME_W-1:0]  armed_at_q = '0;

    poll_report_t poll_reports_q[$];
    int           polls_sent = 0;
    int           fault_count = 0;
    logic [31:0]  tick = '0;
    int unsigned  step_max = 0;
    int           tx_mode = 0;
    int           rx_mode = 0;
    bit           idle_locked = 1'b0;
    int           rx_hold_cycles = 0;

    function automatic logic span_passed(input logic [31:0] t_now, input logic [31:0] t_ref,
                                         input logic [31:0] span);
        logic [31:0] diff;
        diff = t_now - t_ref;
        return diff > span;
    endfunction

    function automatic logic busy_flag();
        int n;
        n = (cfg_used > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(cfg_used);
        for (int i = 0; i < n; i++) begin
            if ((integ_q[i] != INTEG_REST && integ_q[i] != cfg_top) || pressed_q[i] ||
                clicks_q[i] != 0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic poll_report_t classify_poll(input logic [1:0] b, input logic pin,
                                                   input logic [31:0] t);
        poll_report_t r;
        r = '0;
        if (armed_q && span_passed(t, armed_at_q, cfg_window))
            armed_q = 1'b0;
        if (pin) begin
            if (pressed_q[b] && span_passed(t, press_time_q[b], cfg_gap) &&
                phase_q[b] == HP_NONE) begin
                phase_q[b] = HP_PRESENT;
                if (!armed_q) begin
                    r.hold_event = HOLD_START;
                end else begin
                    r.hold_event = HOLD_FR_START;
                    armed_q = 1'b0;
                end
            end
            if (integ_q[b] != cfg_top) begin
                integ_q[b] = integ_q[b] + 8'd1;
                if (integ_q[b] == cfg_top) begin
                    pressed_q[b] = 1'b1;
                    r.press_edge = 1'b1;
                    if (!span_passed(t, press_time_q[b], cfg_gap)) begin
                        if (clicks_q[b] < CLICK_MAX)
                            clicks_q[b] = clicks_q[b] + 4'd1;
                    end else begin
                        clicks_q[b] = 4'd1;
                    end
                    press_time_q[b] = t;
                end
            end
        end else if (integ_q[b] != INTEG_REST) begin
            integ_q[b] = integ_q[b] - 8'd1;
            if (integ_q[b] == INTEG_REST && (pressed_q[b] || phase_q[b] == HP_FIXED)) begin
                released_q[b] = 1'b1;
                r.release_edge = 1'b1;
            end
        end

        if (released_q[b] && span_passed(t, press_time_q[b], cfg_gap)) begin
            if (clicks_q[b] >= FR_CLICKS) begin
                armed_q = 1'b1;
                armed_at_q = t;
                r.gesture = GEST_RESET_ARMED;
            end else if (phase_q[b] != HP_NONE) begin
                r.gesture = GEST_HOLD_RELEASE;
            end else if (clicks_q[b] == BATTERY_CLICKS) begin
                r.gesture = GEST_BATTERY;
            end else begin
                case (clicks_q[b])
                    4'd1: r.gesture = GEST_SINGLE;
                    4'd2: r.gesture = GEST_DOUBLE;
                    4'd3: r.gesture = GEST_TRIPLE;
                    default: r.gesture = GEST_NONE;
                endcase
            end
            clicks_q[b] = '0;
            pressed_q[b] = 1'b0;
            released_q[b] = 1'b0;
            phase_q[b] = HP_NONE;
        end else if (pressed_q[b] && clicks_q[b] == 4'd1 && phase_q[b] == HP_PRESENT) begin
            // a single long press turns into a fixed hold
            phase_q[b] = HP_FIXED;
            clicks_q[b] = '0;
            pressed_q[b] = 1'b0;
        end
        r.busy = busy_flag();
        return r;
    endfunction

    function automatic int draw_idle(input int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 12)) : 0;
            default: return int'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic send_poll(input logic [1:0] b, input logic pin, input logic [31:0] t);
        int gap;
        gap = draw_idle(tx_mode);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, t, pin, b};
        do @(posedge aclk); while (!s_tready);
        poll_reports_q.push_back(classify_poll(b, pin, t));
        polls_sent++;
    endtask

    task automatic poll(input logic [1:0] b, input logic pin);
        if (!idle_locked && $urandom_range(0, 39) == 0) begin
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
        end
        tick += $urandom_range(0, step_max);
        send_poll(b, pin, tick);
    endtask

    task automatic await_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (poll_reports_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0]       junk;
        logic [31:0]       wdata;
        longint unsigned   q;
        junk = $urandom();
        wdata = value;
        // unused upper bits carry noise
        if (idx == CFG_DEBOUNCE_TOP)
            wdata = {junk[31:8], value[7:0]};
        if (idx == CFG_BUTTONS_USED)
            wdata = {junk[31:3], value[2:0]};
        await_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TOP: cfg_top = value[7:0];
            CFG_CLICK_GAP:    cfg_gap = value;
            CFG_ARM_WINDOW:   cfg_window = value;
            CFG_BUTTONS_USED: cfg_used = value[2:0];
            default: ;
        endcase
        // keep poll spacing well inside the click gap
        q = longint'(cfg_gap) / (4 * (longint'(cfg_top) + 4));
        if (q > 1000)
            q = 1000;
        step_max = q[31:0];
    endtask

    task automatic press_button(input logic [1:0] b, input bit bouncy);
        int guard;
        guard = 0;
        while (integ_q[b] != cfg_top && guard < 300) begin
            if (bouncy && $urandom_range(0, 7) == 0)
                poll(b, 1'b0);
            else
                poll(b, 1'b1);
            guard++;
        end
    endtask

    task automatic release_button(input logic [1:0] b, input bit bouncy);
        int guard;
        guard = 0;
        while (integ_q[b] != INTEG_REST && guard < 300) begin
            if (bouncy && $urandom_range(0, 7) == 0)
                poll(b, 1'b1);
            else
                poll(b, 1'b0);
            guard++;
        end
    endtask

    // quiet poll after the gap so the sequence gets classified
    task automatic settle(input logic [1:0] b);
        longint unsigned quiet_span;
        quiet_span = longint'(cfg_gap) + 1 + $urandom_range(0, 40);
        tick += quiet_span[31:0];
        send_poll(b, 1'b0, tick);
    endtask

    task automatic click_run(input logic [1:0] b, input int n, input bit bouncy);
        repeat (n) begin
            press_button(b, bouncy);
            release_button(b, bouncy);
        end
        settle(b);
    endtask

    task automatic hold_run(input logic [1:0] b, input int extra);
        longint unsigned hold_span;
        press_button(b, 1'b0);
        hold_span = longint'(cfg_gap) + 1 + $urandom_range(0, 40);
        tick += hold_span[31:0];
        send_poll(b, 1'b1, tick);
        poll(b, 1'b1);
        release_button(b, 1'b0);
        repeat (extra) begin
            press_button(b, 1'($urandom_range(0, 1)));
            release_button(b, 1'($urandom_range(0, 1)));
        end
        settle(b);
    endtask

    task automatic arm_sequence(input bit expire);
        logic [1:0]      b1;
        logic [1:0]      b2;
        longint unsigned lapse;
        b1 = 2'($urandom_range(0, 3));
        b2 = 2'($urandom_range(0, 3));
        click_run(b1, $urandom_range(5, 8), 1'($urandom_range(0, 1)));
        if (expire) begin
            lapse = longint'(cfg_window) + 1 + $urandom_range(0, 40);
            tick += lapse[31:0];
            send_poll(b2, 1'b0, tick);
        end
        hold_run(b2, $urandom_range(0, 6));
    endtask

    task automatic noise_burst(input int k);
        repeat (k) begin
            if ($urandom_range(0, 9) == 0)
                tick = $urandom();
            else
                tick += $urandom_range(0, 4 * step_max + 3);
            send_poll(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), tick);
        end
    endtask

    task automatic random_gesture();
        logic [1:0] b;
        b = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: click_run(b, $urandom_range(1, 4), 1'($urandom_range(0, 1)));
            5: click_run(b, $urandom_range(5, 8), 1'($urandom_range(0, 1)));
            6: hold_run(b, 0);
            7: hold_run(b, $urandom_range(1, 6));
            8: noise_burst($urandom_range(4, 12));
            default: arm_sequence(1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic gesture_burst(input int n);
        int stop;
        stop = polls_sent + n;
        while (polls_sent < stop) random_gesture();
    endtask

    task automatic test_directed();
        write_reg(CFG_DEBOUNCE_TOP, 32'd2);
        write_reg(CFG_CLICK_GAP, 32'd10);
        write_reg(CFG_ARM_WINDOW, 32'd100);
        write_reg(CFG_BUTTONS_USED, 32'd4);
        // single click on the top button across the wrap of the tick counter
        send_poll(2'd3, 1'b1, 32'hFFFF_FFFE);
        send_poll(2'd3, 1'b0, 32'hFFFF_FFFF);
        send_poll(2'd3, 1'b0, 32'd12);
        // double click on button zero starting at tick zero
        send_poll(2'd0, 1'b1, 32'd0);
        send_poll(2'd0, 1'b0, 32'd1);
        send_poll(2'd0, 1'b1, 32'd2);
        send_poll(2'd0, 1'b0, 32'd3);
        send_poll(2'd0, 1'b0, 32'd20);
        // hold, then release after hold on the same poll as the classification
        send_poll(2'd1, 1'b1, 32'd100);
        send_poll(2'd1, 1'b1, 32'd120);
        send_poll(2'd1, 1'b0, 32'd121);
        // five clicks arm the reset, the next hold reports factory reset start
        for (int i = 0; i < 5; i++) begin
            send_poll(2'd2, 1'b1, 32'd200 + 2 * i);
            send_poll(2'd2, 1'b0, 32'd201 + 2 * i);
        end
        send_poll(2'd2, 1'b0, 32'd230);
        send_poll(2'd1, 1'b1, 32'd240);
        send_poll(2'd1, 1'b1, 32'd260);
        send_poll(2'd1, 1'b0, 32'd261);
        tick = 32'd400;
    endtask

    task automatic test_click_gestures();
        int stop;
        write_reg(CFG_DEBOUNCE_TOP, 32'd5);
        write_reg(CFG_CLICK_GAP, 32'd750);
        write_reg(CFG_ARM_WINDOW, 32'd3000);
        write_reg(CFG_BUTTONS_USED, 32'd1);
        stop = polls_sent + 450;
        while (polls_sent < stop)
            click_run(2'($urandom_range(0, 3)), $urandom_range(1, 4),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_hold_and_arming();
        int stop;
        write_reg(CFG_DEBOUNCE_TOP, 32'd4);
        write_reg(CFG_CLICK_GAP, 32'd200);
        write_reg(CFG_ARM_WINDOW, 32'd1500);
        write_reg(CFG_BUTTONS_USED, 32'd3);
        stop = polls_sent + 250;
        while (polls_sent < stop) begin
            case ($urandom_range(0, 2))
                0: arm_sequence(1'b0);
                1: arm_sequence(1'b1);
                default: hold_run(2'($urandom_range(0, 3)), $urandom_range(0, 6));
            endcase
        end
    endtask

    task automatic test_click_saturation();
        write_reg(CFG_DEBOUNCE_TOP, 32'd2);
        write_reg(CFG_CLICK_GAP, 32'd50);
        repeat (4) click_run(2'($urandom_range(0, 3)), $urandom_range(16, 20), 1'b0);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_BUTTONS_USED, 32'd4);
        write_reg(CFG_CLICK_GAP, 32'd750);
        write_reg(CFG_ARM_WINDOW, 32'd3000);
        write_reg(CFG_DEBOUNCE_TOP, 32'd255);
        press_button(2'd2, 1'b0);
        // top lowered below the integrator value, reached by wrapping
        write_reg(CFG_DEBOUNCE_TOP, 32'd0);
        repeat (2) poll(2'd2, 1'b1);
        repeat (3) poll(2'd2, 1'b0);
        // a top of one gives no press in these polls
        write_reg(CFG_DEBOUNCE_TOP, 32'd1);
        repeat (3) poll(2'd2, 1'b1);
        repeat (3) poll(2'd2, 1'b0);
        write_reg(CFG_DEBOUNCE_TOP, 32'd2);
        click_run(2'd2, 2, 1'b0);
        write_reg(CFG_BUTTONS_USED, 32'd7);
        write_reg(CFG_CLICK_GAP, 32'd1);
        write_reg(CFG_ARM_WINDOW, 32'd1);
        gesture_burst(40);
        write_reg(CFG_BUTTONS_USED, 32'd0);
        write_reg(CFG_CLICK_GAP, 32'hFFFF_FFFF);
        write_reg(CFG_ARM_WINDOW, 32'hFFFF_FFFF);
        gesture_burst(40);
        write_reg(CFG_BUTTONS_USED, 32'd2);
        write_reg(CFG_CLICK_GAP, 32'd1);
        gesture_burst(40);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_DEBOUNCE_TOP, 32'd3);
        write_reg(CFG_CLICK_GAP, 32'd300);
        idle_locked = 1'b1;
        tx_mode = 0;
        rx_mode = 0;
        repeat (2) begin
            rx_hold_cycles = $urandom_range(60, 120);
            gesture_burst(30);
        end
        idle_locked = 1'b0;
    endtask

    task automatic test_random_mix();
        int next_cfg;
        next_cfg = polls_sent;
        while (polls_sent < 1800) begin
            if (polls_sent >= next_cfg) begin
                write_reg(CFG_DEBOUNCE_TOP, $urandom_range(2, 8));
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_CLICK_GAP, 32'd1);
                    1: write_reg(CFG_CLICK_GAP, $urandom_range(2, 30));
                    default: write_reg(CFG_CLICK_GAP, $urandom_range(100, 2000));
                endcase
                if ($urandom_range(0, 5) == 0)
                    write_reg(CFG_ARM_WINDOW, 32'hFFFF_FFFF);
                else
                    write_reg(CFG_ARM_WINDOW, $urandom_range(1, 10000));
                write_reg(CFG_BUTTONS_USED, $urandom_range(0, 7));
                next_cfg = polls_sent + 150;
            end
            random_gesture();
        end
    endtask

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = draw_idle(rx_mode);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        poll_report_t seen;
        poll_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (poll_reports_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result transaction %h", m_tdata);
            end else begin
                want = poll_reports_q.pop_front();
                if (seen.hold_event != want.hold_event || seen.gesture != want.gesture ||
                    seen.press_edge != want.press_edge ||
                    seen.release_edge != want.release_edge || seen.busy != want.busy) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $write("mismatch: hold %0d/%0d gesture %0d/%0d ",
                               want.hold_event, seen.hold_event, want.gesture, seen.gesture);
                        $display("press %0b/%0b release %0b/%0b busy %0b/%0b (expected/actual)",
                                 want.press_edge, seen.press_edge, want.release_edge,
                                 seen.release_edge, want.busy, seen.busy);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[button_multiclick_classifier_core] ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
            integ_q[i] = INTEG_REST;
            pressed_q[i] = 1'b0;
            released_q[i] = 1'b0;
            phase_q[i] = HP_NONE;
            clicks_q[i] = '0;
            press_time_q[i] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_click_gestures();
        test_hold_and_arming();
        test_click_saturation();
        test_register_extremes();
        test_backpressure();
        test_random_mix();

        await_idle();
        repeat (4) @(posedge aclk);
        if (fault_count == 0 && poll_reports_q.size() == 0)
            $display("[button_multiclick_classifier_core] OK");
        else
            $display("[button_multiclick_classifier_core] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/bmc_pkg.sv
hdl/button_multiclick_classifier_core.sv
verif/testbench.sv
